>>> sv/bah_pkg.sv
// Shared types and codes of the bucketed address hash set.
package bah_pkg;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
  } request_t;

  typedef struct packed {
    logic       found;
    logic [1:0] insert_status;
  } result_t;

endpackage

>>> sv/bah_hash.sv
// Iterative bucket hash: one shared 32x32 multiplier serves the hash and the remainder.
module bah_hash #(
  parameter int BUCKETS = 1024,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   address,
  output logic          done,
  output logic [BW-1:0] bucket
);
  import bah_pkg::*;

  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  // Scaled reciprocal of the bucket count, used only when the count is not a power of two.
  localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(BUCKETS);
  localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
  localparam logic [31:0] BUCKETS_W  = 32'(BUCKETS);

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_LO   = 3'd1;
  localparam logic [2:0] H_HI   = 3'd2;
  localparam logic [2:0] H_MQ   = 3'd3;
  localparam logic [2:0] H_MR   = 3'd4;
  localparam logic [2:0] H_MFIX = 3'd5;
  localparam logic [2:0] H_DONE = 3'd6;

  logic [2:0]    hstate;
  logic [63:0]   a;
  logic [63:0]   h;
  logic [BW-1:0] r;
  logic [1:0]    k;
  logic [31:0]   q;
  logic [31:0]   t;

  logic [31:0]   x;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  logic [31:0]   t_red;

  // The remainder is taken sixteen bits at a time: the running remainder is below the
  // bucket count, so the partial dividend fits in 32 bits and the quotient estimate
  // from the reciprocal is low by at most one.
  assign x = {16'(r), h[63:48]};

  always_comb begin
    unique case (hstate)
      H_HI: begin
        mul_a = a[63:32];
        mul_b = HASH_MULT;
      end
      H_MQ: begin
        mul_a = x;
        mul_b = RECIP;
      end
      H_MR: begin
        mul_a = q;
        mul_b = BUCKETS_W;
      end
      default: begin
        mul_a = a[31:0];
        mul_b = HASH_MULT;
      end
    endcase
  end

  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
  assign t_red = (t >= BUCKETS_W) ? t - BUCKETS_W : t;

  assign done   = (hstate == H_DONE);
  assign bucket = IS_POW2 ? (h[BW-1:0] & BW'(BUCKETS - 1)) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
    end else begin
      unique case (hstate)
        H_IDLE: begin
          if (start) begin
            a      <= address;
            hstate <= H_LO;
          end
        end
        H_LO: begin
          h      <= prod;
          hstate <= H_HI;
        end
        H_HI: begin
          // Only the low word of the high partial product survives the 64-bit wrap.
          h <= {h[63:32] + prod[31:0], h[31:0]};
          r <= '0;
          k <= '0;
          hstate <= IS_POW2 ? H_DONE : H_MQ;
        end
        H_MQ: begin
          q      <= prod[63:32];
          hstate <= H_MR;
        end
        H_MR: begin
          t      <= x - prod[31:0];
          hstate <= H_MFIX;
        end
        H_MFIX: begin
          r <= t_red[BW-1:0];
          h <= {h[47:0], 16'd0};
          k <= k + 2'd1;
          if (k == 2'd3) begin
            hstate <= H_DONE;
          end else begin
            hstate <= H_MQ;
          end
        end
        H_DONE: begin
          hstate <= H_IDLE;
        end
        default: begin
          hstate <= H_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/bucketed_address_hash_set_unit.sv
// Bucketed address hash set: a set of 64-bit addresses held in BUCKETS buckets of
// SLOTS_PER_BUCKET slots, answering lookup, insert and clear requests one at a time.
// After reset the block clears its fill-count memory in a pass over all BUCKETS entries and
// accepts no request meanwhile; a clear request runs the same pass and then answers.
// A lookup or insert passes twice through the shared hash multiplier; when BUCKETS is
// not a power of two it then takes the remainder sixteen bits at a time through that
// same multiplier. It then compares one slot per cycle, from the registered read port
// of the slot memory, up to the bucket's fill count. The next request is accepted only
// after the result of the last one has been loaded.
module bucketed_address_hash_set_unit #(
  parameter int BUCKETS          = 1024,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  bah_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output bah_pkg::result_t  result
);
  import bah_pkg::*;

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SIW   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int DEPTH = BUCKETS * SLOTS_PER_BUCKET;
  localparam int SAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]     state, state_next;
  logic [1:0]     req_type, req_type_next;
  logic [63:0]    address, address_next;
  logic [BW-1:0]  bucket, bucket_next;
  logic [FW-1:0]  fill_n, fill_n_next;
  logic [SIW-1:0] slot_idx, slot_idx_next;
  logic [BW-1:0]  clr_idx, clr_idx_next;
  logic           res_found, res_found_next;
  logic [1:0]     res_status, res_status_next;
  logic           result_valid_next;
  logic           result_load;

  logic           hash_start;
  logic           hash_done;
  logic [BW-1:0]  hash_bucket;

  // Fill counts double as the occupied marks: a bucket is occupied exactly when
  // its count is nonzero.
  logic [FW-1:0]  fill_mem [BUCKETS];
  logic [63:0]    slot_mem [DEPTH];
  logic [FW-1:0]  fill_q;
  logic [63:0]    slot_q;

  logic           fill_we;
  logic [BW-1:0]  fill_waddr;
  logic [FW-1:0]  fill_wdata;
  logic           slot_we;
  logic [SAW-1:0] slot_waddr;
  logic [SAW-1:0] slot_raddr;
  logic [SAW-1:0] slot_base;
  logic [FW-1:0]  cur_fill;
  logic [FW-1:0]  slot_cnt;
  logic [SIW-1:0] rd_slot;

  bah_hash #(
    .BUCKETS(BUCKETS)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .address(request.address),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  assign request_stall = (state != S_IDLE);

  assign slot_base  = SAW'(bucket) * SAW'(SLOTS_PER_BUCKET);
  assign cur_fill   = (state == S_FILL) ? fill_q : fill_n;
  assign slot_cnt   = FW'(slot_idx) + FW'(1);
  // While scanning, the read port fetches the slot after the one being compared.
  assign rd_slot    = ((state == S_SCAN) && (slot_cnt < FW'(SLOTS_PER_BUCKET))) ?
                      SIW'(slot_cnt) : '0;
  assign slot_raddr = slot_base + SAW'(rd_slot);
  assign slot_waddr = slot_base + SAW'(cur_fill);

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_q <= fill_mem[hash_bucket];
    if (slot_we) begin
      slot_mem[slot_waddr] <= address;
    end
    slot_q <= slot_mem[slot_raddr];
  end

  always_comb begin
    state_next      = state;
    req_type_next   = req_type;
    address_next    = address;
    bucket_next     = bucket;
    fill_n_next     = fill_n;
    slot_idx_next   = slot_idx;
    clr_idx_next    = clr_idx;
    res_found_next  = res_found;
    res_status_next = res_status;
    result_load     = 1'b0;
    hash_start      = 1'b0;
    fill_we         = 1'b0;
    fill_waddr      = bucket;
    fill_wdata      = cur_fill + FW'(1);
    slot_we         = 1'b0;

    unique case (state)
      S_INIT, S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_idx;
        fill_wdata = '0;
        if (clr_idx == BW'(BUCKETS - 1)) begin
          res_found_next  = 1'b0;
          res_status_next = ST_NONE;
          state_next      = (state == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          clr_idx_next = clr_idx + BW'(1);
        end
      end
      S_IDLE: begin
        if (request_valid) begin
          req_type_next   = request.req_type;
          address_next    = request.address;
          clr_idx_next    = '0;
          slot_idx_next   = '0;
          res_found_next  = 1'b0;
          res_status_next = ST_NONE;
          unique case (request.req_type)
            REQ_LOOKUP, REQ_INSERT: begin
              hash_start = 1'b1;
              state_next = S_HASH;
            end
            REQ_CLEAR: begin
              state_next = S_CLEAR;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bucket_next = hash_bucket;
          state_next  = S_FILL;
        end
      end
      S_FILL: begin
        fill_n_next   = fill_q;
        slot_idx_next = '0;
        if ((req_type == REQ_INSERT) && (fill_q >= FW'(SLOTS_PER_BUCKET))) begin
          res_status_next = ST_FULL;
          state_next      = S_DONE;
        end else if (fill_q == '0) begin
          if (req_type == REQ_INSERT) begin
            fill_we         = 1'b1;
            slot_we         = 1'b1;
            res_status_next = ST_INSERTED;
          end
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (slot_q == address) begin
          if (req_type == REQ_INSERT) begin
            res_status_next = ST_PRESENT;
          end else begin
            res_found_next = 1'b1;
          end
          state_next = S_DONE;
        end else if (slot_cnt >= fill_n) begin
          if (req_type == REQ_INSERT) begin
            fill_we         = 1'b1;
            slot_we         = 1'b1;
            res_status_next = ST_INSERTED;
          end
          state_next = S_DONE;
        end else begin
          slot_idx_next = SIW'(slot_cnt);
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        clr_idx_next = '0;
        state_next   = S_INIT;
      end
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (result_load) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      clr_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr_idx      <= clr_idx_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_type   <= req_type_next;
    address    <= address_next;
    bucket     <= bucket_next;
    fill_n     <= fill_n_next;
    slot_idx   <= slot_idx_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    if (result_load) begin
      result.found         <= res_found;
      result.insert_status <= res_status;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_we |-> (fill_wdata <= FW'(SLOTS_PER_BUCKET)))
    else $error("fill count written beyond the slot count");

  a_hash_in_hash_state: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == S_HASH))
    else $error("hash finished outside the hash wait");

  a_scan_below_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ((fill_n != '0) && (FW'(slot_idx) < fill_n)))
    else $error("slot scan past the bucket fill count");

  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    slot_we |-> ((req_type == REQ_INSERT) && (cur_fill < FW'(SLOTS_PER_BUCKET))))
    else $error("slot written outside a non-full insert");

endmodule

>>> tb/sv/bucketed_address_hash_set_unit_test.sv
// Self-checking testbench of the bucketed address hash set: directed table, then random traffic.
module bucketed_address_hash_set_unit_test;
  import bah_pkg::*;

  localparam int N_BUCKETS = 1024;
  localparam int N_SLOTS = 4;
  localparam int N_HOT = 3;
  localparam int RANDOM_PER_PHASE = 650;
  localparam int IDLE_LIMIT = 8000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] addr;
    logic        typed;
    logic        exp_found;
    logic [1:0]  exp_status;
  } dir_row_t;

  localparam int N_DIR = 24;

  // Rows with typed set carry their own expected result; the rest use the predictor.
  dir_row_t dir_table [N_DIR] = '{
    {REQ_LOOKUP, 64'h0, 1'b1, 1'b0, ST_NONE},
    {REQ_LOOKUP, ALL_ONES, 1'b1, 1'b0, ST_NONE},
    {REQ_INSERT, 64'h0, 1'b1, 1'b0, ST_INSERTED},
    {REQ_INSERT, 64'h0, 1'b1, 1'b0, ST_PRESENT},
    {REQ_LOOKUP, 64'h0, 1'b1, 1'b1, ST_NONE},
    {REQ_INSERT, ALL_ONES, 1'b1, 1'b0, ST_INSERTED},
    {REQ_LOOKUP, ALL_ONES, 1'b1, 1'b1, ST_NONE},
    {REQ_INSERT, 64'h400, 1'b1, 1'b0, ST_INSERTED},
    {REQ_INSERT, 64'h800, 1'b1, 1'b0, ST_INSERTED},
    {REQ_INSERT, 64'h8000_0000_0000_0000, 1'b1, 1'b0, ST_INSERTED},
    {REQ_INSERT, 64'hC00, 1'b1, 1'b0, ST_FULL},
    {REQ_INSERT, 64'h0, 1'b1, 1'b0, ST_FULL},
    {REQ_LOOKUP, 64'h800, 1'b1, 1'b1, ST_NONE},
    {REQ_LOOKUP, 64'hC00, 1'b1, 1'b0, ST_NONE},
    {REQ_UNUSED, ALL_ONES, 1'b1, 1'b0, ST_NONE},
    {REQ_LOOKUP, 64'h0, 1'b1, 1'b1, ST_NONE},
    {REQ_CLEAR, 64'h5555_5555_5555_5555, 1'b1, 1'b0, ST_NONE},
    {REQ_LOOKUP, 64'h0, 1'b1, 1'b0, ST_NONE},
    {REQ_INSERT, 64'h400, 1'b1, 1'b0, ST_INSERTED},
    {REQ_LOOKUP, 64'h800, 1'b1, 1'b0, ST_NONE},
    {REQ_INSERT, 64'h5555_5555_5555_5555, 1'b0, 1'b0, ST_NONE},
    {REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, ST_NONE},
    {REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, ST_NONE},
    {REQ_CLEAR, ALL_ONES, 1'b1, 1'b0, ST_NONE}
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  request_t request = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  result_t  result;

  bit          occupied_q [N_BUCKETS];
  int          fill_q [N_BUCKETS];
  logic [63:0] slots_q [N_BUCKETS][N_SLOTS];

  result_t     expected_results [$];
  logic [63:0] recent_inserts [$];
  logic [9:0]  hot_low [N_HOT];
  int          req_idle_pct = 0;
  int          res_stall_pct = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;

  bucketed_address_hash_set_unit #(
    .BUCKETS         (N_BUCKETS),
    .SLOTS_PER_BUCKET(N_SLOTS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t predict_hash_set(input request_t r);
    result_t     res;
    logic [63:0] prod;
    int          b;
    bit          hit;
    res.found = 1'b0;
    res.insert_status = ST_NONE;
    prod = r.address * 64'(HASH_MULT);
    b = int'(prod % 64'(N_BUCKETS));
    hit = 1'b0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (i < fill_q[b] && slots_q[b][i] == r.address) hit = 1'b1;
    end
    case (r.req_type)
      REQ_LOOKUP: begin
        res.found = occupied_q[b] && hit;
      end
      REQ_INSERT: begin
        if (fill_q[b] >= N_SLOTS) begin
          res.insert_status = ST_FULL;
        end else if (hit) begin
          res.insert_status = ST_PRESENT;
        end else begin
          slots_q[b][fill_q[b]] = r.address;
          fill_q[b]++;
          occupied_q[b] = 1'b1;
          res.insert_status = ST_INSERTED;
        end
      end
      REQ_CLEAR: begin
        // Slot contents survive a clear; only the fill counts gate the scan.
        for (int k = 0; k < N_BUCKETS; k++) begin
          occupied_q[k] = 1'b0;
          fill_q[k] = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // With a power-of-two bucket count and an odd multiplier, the bucket depends only on
  // the low ten address bits, so fixing those bits aims many addresses at one bucket.
  function automatic logic [63:0] pick_address();
    logic [63:0] a;
    int          roll;
    roll = $urandom_range(99);
    a = {$urandom, $urandom};
    if (roll < 30 && recent_inserts.size() > 0) begin
      a = recent_inserts[$urandom_range(recent_inserts.size() - 1)];
    end else if (roll < 75) begin
      a[9:0] = hot_low[$urandom_range(N_HOT - 1)];
    end
    return a;
  endfunction

  task automatic send_request(input request_t r);
    @(negedge clk);
    while ($urandom_range(99) < req_idle_pct) begin
      request_valid <= 1'b0;
      @(negedge clk);
    end
    request_valid <= 1'b1;
    request <= r;
    @(posedge clk);
    while (request_stall) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < res_stall_pct);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: found=%0b status=%0d",
                                result.found, result.insert_status));
      end else begin
        want = expected_results.pop_front();
        if (result.found !== want.found || result.insert_status !== want.insert_status) begin
          flag_mismatch($sformatf("result mismatch: expected found=%0b status=%0d, got found=%0b status=%0d",
                                  want.found, want.insert_status,
                                  result.found, result.insert_status));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("** bucketed_address_hash_set_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    request_t r;
    result_t  predicted;
    int       roll;
    for (int k = 0; k < N_BUCKETS; k++) begin
      occupied_q[k] = 1'b0;
      fill_q[k] = 0;
    end
    for (int h = 0; h < N_HOT; h++) hot_low[h] = 10'($urandom_range(1023));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    req_idle_pct = 34;
    res_stall_pct = 67;
    for (int i = 0; i < N_DIR; i++) begin
      r.req_type = dir_table[i].kind;
      r.address = dir_table[i].addr;
      send_request(r);
      predicted = predict_hash_set(r);
      if (dir_table[i].typed) begin
        predicted.found = dir_table[i].exp_found;
        predicted.insert_status = dir_table[i].exp_status;
      end
      expected_results.push_back(predicted);
    end

    for (int phase = 0; phase < 3; phase++) begin
      req_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 67 : 0;
      res_stall_pct = (phase == 0) ? 67 : (phase == 1) ? 34 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 42) r.req_type = REQ_LOOKUP;
        else if (roll < 90) r.req_type = REQ_INSERT;
        else if (roll < 91) r.req_type = REQ_CLEAR;
        else r.req_type = REQ_UNUSED;
        r.address = (r.req_type == REQ_LOOKUP || r.req_type == REQ_INSERT) ?
                    pick_address() : {$urandom, $urandom};
        send_request(r);
        expected_results.push_back(predict_hash_set(r));
        if (r.req_type == REQ_INSERT) begin
          recent_inserts.push_back(r.address);
          if (recent_inserts.size() > 64) void'(recent_inserts.pop_front());
        end
      end
    end
    @(negedge clk);
    request_valid <= 1'b0;

    // The watchdog bounds this wait if a transaction never comes back.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** bucketed_address_hash_set_unit: PASSED **");
    end else begin
      $display("** bucketed_address_hash_set_unit: FAILED **");
    end
    $finish;
  end

endmodule
